### design/csvfs_pkg.sv
// Package for the CSV record and field splitter.
// Character codes and the queue entry and status types; no dependencies.
package csvfs_pkg;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] DELIM_RESET  = 8'h2C;

  // One classified input byte: a first result and an optional closing field.
  typedef struct packed {
    logic [7:0] res_byte;
    logic       byte_valid;
    logic       field_end;
    logic       record_end;
    logic       has_close;
  } csvfs_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } csvfs_q_stat_t;

endpackage

### design/csvfs_ifs.sv
// Valid/ready stream interfaces for the splitter's byte input and result output.
// Depends on nothing.
interface csvfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface csvfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       field_end;
  logic       record_end;
  logic       last;

  modport source (output valid, out_byte, byte_valid, field_end, record_end, last,
                  input ready);
  modport sink   (input valid, out_byte, byte_valid, field_end, record_end, last,
                  output ready);
endinterface

### design/csv_record_field_splitter.sv
// CSV record and field splitter, top level.
// Depends on csvfs_pkg, csvfs_ifs, csvfs_front, csvfs_queue and csvfs_back.
//
// Usage:
//   in_s  : one CSV byte per request (data_byte, last_byte), valid/ready.
//   out_m : results (out_byte, byte_valid, field_end, record_end, last).
//   cfg_we/cfg_wdata : writes the delimiter byte (reset: comma); write only
//   while the block is idle.
// Each byte gives zero, one or two results; last marks the final one.
// Throughput: one byte per cycle while bytes give at most one result and the
// receiver takes every result; a byte with two results holds the output
// register for both, and the QUEUE_DEPTH-entry queue absorbs the difference.
// With the queue empty, an accepted byte reaches its first result through a
// queue write, then an output register load.
// Reset: rst_n low clears quoting state, the queue and the output register
// and sets the delimiter to comma.
// Receiver stall: the output register holds; bytes are still taken until
// the queue fills, then in_s.ready drops.
module csv_record_field_splitter #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  csvfs_in_if.sink    in_s,
  csvfs_out_if.source out_m,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  import csvfs_pkg::*;

  logic          push;
  logic          pop;
  csvfs_entry_t  push_entry;
  csvfs_entry_t  head;
  csvfs_q_stat_t q_stat;

  csvfs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_s       (in_s),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  csvfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  csvfs_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_m  (out_m)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full))
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_stat.empty))
    else $error("queue read while empty");

  a_rend_needs_fend: assert property (@(posedge clk) disable iff (!rst_n)
    out_m.valid && out_m.record_end |-> out_m.field_end && !out_m.byte_valid)
    else $error("record end without field end");

  a_close_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_m.valid && out_m.ready && !out_m.last |=>
      out_m.valid && out_m.field_end && out_m.record_end && out_m.last)
    else $error("second result of a byte missing");
`endif

endmodule

### design/csvfs_front.sv
// Front end: accepts bytes, tracks quoting and record state, classifies results.
// Depends on csvfs_pkg and csvfs_in_if.
module csvfs_front (
  input  logic                   clk,
  input  logic                   rst_n,
  csvfs_in_if.sink               in_s,
  input  logic                   cfg_we,
  input  logic [7:0]             cfg_wdata,
  input  csvfs_pkg::csvfs_q_stat_t q_stat,
  output logic                   push,
  output csvfs_pkg::csvfs_entry_t push_entry
);
  import csvfs_pkg::*;

  logic [7:0] delim_r;
  logic field_quoted_r, field_quoted_nxt;
  logic quote_pending_r, quote_pending_nxt;
  logic quote_parity_r, quote_parity_nxt;
  logic after_bs_r, after_bs_nxt;
  logic record_open_r, record_open_nxt;

  logic       accept;
  logic       r0_valid, r0_bv, r0_fe, r0_re;
  logic [7:0] r0_byte;
  logic       close_extra;

  assign in_s.ready = !q_stat.full;
  assign accept     = in_s.valid && in_s.ready;

  always_comb begin
    logic [7:0] b;
    logic       taken;
    logic       is_nl;
    b                 = in_s.data_byte;
    is_nl             = (b == CH_LF) || (b == CH_CR);
    taken             = 1'b0;
    field_quoted_nxt  = field_quoted_r;
    quote_pending_nxt = quote_pending_r;
    record_open_nxt   = record_open_r;
    after_bs_nxt      = (b == CH_BACKSLASH);
    quote_parity_nxt  = quote_parity_r ^ ((b == CH_QUOTE) && !after_bs_r);
    r0_valid          = 1'b0;
    r0_byte           = 8'd0;
    r0_bv             = 1'b0;
    r0_fe             = 1'b0;
    r0_re             = 1'b0;
    close_extra       = 1'b0;

    if (is_nl && !quote_parity_nxt) begin
      if (record_open_r) begin
        r0_valid = 1'b1;
        r0_fe    = 1'b1;
        r0_re    = 1'b1;
      end
      field_quoted_nxt  = 1'b0;
      quote_pending_nxt = 1'b0;
      record_open_nxt   = 1'b0;
    end else begin
      record_open_nxt = 1'b1;
      if (quote_pending_r) begin
        quote_pending_nxt = 1'b0;
        if (b == CH_QUOTE) begin
          r0_valid = 1'b1;
          r0_byte  = b;
          r0_bv    = 1'b1;
          taken    = 1'b1;
        end else begin
          field_quoted_nxt = 1'b0;
        end
      end
      if (!taken) begin
        if (!field_quoted_nxt && (b == delim_r)) begin
          r0_valid = 1'b1;
          r0_fe    = 1'b1;
        end else if (b == CH_QUOTE) begin
          if (field_quoted_nxt) begin
            quote_pending_nxt = 1'b1;
          end else begin
            field_quoted_nxt = 1'b1;
          end
        end else begin
          r0_valid = 1'b1;
          r0_byte  = b;
          r0_bv    = 1'b1;
        end
      end
    end

    if (in_s.last_byte) begin
      close_extra       = record_open_nxt;
      field_quoted_nxt  = 1'b0;
      quote_pending_nxt = 1'b0;
      quote_parity_nxt  = 1'b0;
      after_bs_nxt      = 1'b0;
      record_open_nxt   = 1'b0;
    end
  end

  // A lone closing field travels as the first result.
  always_comb begin
    push = accept && (r0_valid || close_extra);
    if (r0_valid) begin
      push_entry.res_byte   = r0_byte;
      push_entry.byte_valid = r0_bv;
      push_entry.field_end  = r0_fe;
      push_entry.record_end = r0_re;
      push_entry.has_close  = close_extra;
    end else begin
      push_entry.res_byte   = 8'd0;
      push_entry.byte_valid = 1'b0;
      push_entry.field_end  = 1'b1;
      push_entry.record_end = 1'b1;
      push_entry.has_close  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r         <= DELIM_RESET;
      field_quoted_r  <= 1'b0;
      quote_pending_r <= 1'b0;
      quote_parity_r  <= 1'b0;
      after_bs_r      <= 1'b0;
      record_open_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        delim_r <= cfg_wdata;
      end
      if (accept) begin
        field_quoted_r  <= field_quoted_nxt;
        quote_pending_r <= quote_pending_nxt;
        quote_parity_r  <= quote_parity_nxt;
        after_bs_r      <= after_bs_nxt;
        record_open_r   <= record_open_nxt;
      end
    end
  end

endmodule

### design/csvfs_queue.sv
// Short FIFO of classified entries between front and back ends.
// Depends on csvfs_pkg.
module csvfs_queue #(
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  csvfs_pkg::csvfs_entry_t  push_entry,
  input  logic                     pop,
  output csvfs_pkg::csvfs_entry_t  head,
  output csvfs_pkg::csvfs_q_stat_t q_stat
);
  import csvfs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  csvfs_entry_t  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == FULL_CNT);
  assign q_stat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### design/csvfs_back.sv
// Back end: expands queue entries into one or two results into an output register.
// Depends on csvfs_pkg and csvfs_out_if.
module csvfs_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  csvfs_pkg::csvfs_entry_t  head,
  input  csvfs_pkg::csvfs_q_stat_t q_stat,
  output logic                     pop,
  csvfs_out_if.source              out_m
);
  import csvfs_pkg::*;

  logic       valid_r, valid_nxt;
  logic       close_r, close_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       bv_r, bv_nxt;
  logic       fe_r, fe_nxt;
  logic       re_r, re_nxt;
  logic       last_r, last_nxt;
  logic       load;

  assign load = !valid_r || out_m.ready;

  always_comb begin
    pop       = 1'b0;
    valid_nxt = valid_r;
    close_nxt = close_r;
    byte_nxt  = byte_r;
    bv_nxt    = bv_r;
    fe_nxt    = fe_r;
    re_nxt    = re_r;
    last_nxt  = last_r;
    if (load) begin
      if (close_r) begin
        valid_nxt = 1'b1;
        close_nxt = 1'b0;
        byte_nxt  = 8'd0;
        bv_nxt    = 1'b0;
        fe_nxt    = 1'b1;
        re_nxt    = 1'b1;
        last_nxt  = 1'b1;
      end else if (!q_stat.empty) begin
        pop       = 1'b1;
        valid_nxt = 1'b1;
        close_nxt = head.has_close;
        byte_nxt  = head.res_byte;
        bv_nxt    = head.byte_valid;
        fe_nxt    = head.field_end;
        re_nxt    = head.record_end;
        last_nxt  = !head.has_close;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      close_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      close_r <= close_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    bv_r   <= bv_nxt;
    fe_r   <= fe_nxt;
    re_r   <= re_nxt;
    last_r <= last_nxt;
  end

  assign out_m.valid      = valid_r;
  assign out_m.out_byte   = byte_r;
  assign out_m.byte_valid = bv_r;
  assign out_m.field_end  = fe_r;
  assign out_m.record_end = re_r;
  assign out_m.last       = last_r;

endmodule

### test/testbench.sv
// Testbench for csv_record_field_splitter: directed and random CSV byte streams
// with a built-in behavioral predictor and an in-order result checker.
// Depends on csvfs_pkg, csvfs_ifs and the splitter RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import csvfs_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 6;

  typedef struct packed {
    logic [7:0] ob;
    logic       bv;
    logic       fe;
    logic       re;
    logic       is_last;
  } split_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  csvfs_in_if  in_ch ();
  csvfs_out_if out_ch ();

  csv_record_field_splitter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_ch),
    .out_m     (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  split_result_t pending_results[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int random_sent = 0;
  int stall_cycles = 0;

  // predictor state
  logic [7:0] field_sep = DELIM_RESET;
  bit in_quotes = 0;
  bit quote_held = 0;
  bit quote_odd = 0;
  bit prev_backslash = 0;
  bit record_live = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void predict_split(input logic [7:0] b, input logic fin);
    int n;
    bit escaped;
    bit taken;
    n = 0;
    escaped = prev_backslash;
    prev_backslash = (b == CH_BACKSLASH);
    if (b == CH_QUOTE && !escaped) quote_odd = !quote_odd;
    if ((b == CH_LF || b == CH_CR) && !quote_odd) begin
      if (record_live) begin
        pending_results.push_back('{8'h00, 1'b0, 1'b1, 1'b1, 1'b0});
        n++;
      end
      in_quotes = 0;
      quote_held = 0;
      record_live = 0;
    end else begin
      taken = 0;
      record_live = 1;
      if (quote_held) begin
        quote_held = 0;
        if (b == CH_QUOTE) begin
          pending_results.push_back('{b, 1'b1, 1'b0, 1'b0, 1'b0});
          n++;
          taken = 1;
        end else begin
          in_quotes = 0;
        end
      end
      if (!taken) begin
        if (!in_quotes && b == field_sep) begin
          pending_results.push_back('{8'h00, 1'b0, 1'b1, 1'b0, 1'b0});
          n++;
        end else if (b == CH_QUOTE) begin
          if (in_quotes) quote_held = 1;
          else in_quotes = 1;
        end else begin
          pending_results.push_back('{b, 1'b1, 1'b0, 1'b0, 1'b0});
          n++;
        end
      end
    end
    if (fin) begin
      if (record_live) begin
        pending_results.push_back('{8'h00, 1'b0, 1'b1, 1'b1, 1'b0});
        n++;
      end
      in_quotes = 0;
      quote_held = 0;
      quote_odd = 0;
      prev_backslash = 0;
      record_live = 0;
    end
    if (n > 0) pending_results[$].is_last = 1'b1;
  endfunction

  // One request on the input channel; valid stays high if the next one follows at once.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= fin;
    do @(posedge clk); while (!in_ch.ready);
    predict_split(b, fin);
  endtask

  task automatic put_random(input logic [7:0] b);
    send_byte(b, $urandom_range(63) == 0);
    random_sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_delimiter(input logic [7:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    field_sep = v;
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h7E, 8'h20));
    if (c == field_sep || c == CH_QUOTE || c == CH_BACKSLASH) c = 8'h78;
    return c;
  endfunction

  function automatic logic [7:0] any_char();
    case ($urandom_range(7))
      0: return CH_QUOTE;
      1: return field_sep;
      2: return CH_LF;
      3: return CH_CR;
      4: return CH_BACKSLASH;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic test_plain_fields();
    send_byte(8'h00, 1'b0);
    send_byte(DELIM_RESET, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(DELIM_RESET, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_LF, 1'b0);
  endtask

  // doubled quote, held quote closed by a delimiter, newline inside quotes
  task automatic test_quoted_fields();
    string s;
    s = "\"a\"\"b\",\"\n\"\n";
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // escaped quote skips parity; stream end with and without an open record
  task automatic test_escape_and_stream_end();
    send_byte(CH_BACKSLASH, 1'b0);
    send_byte(CH_QUOTE, 1'b0);
    send_byte("c", 1'b0);
    send_byte(CH_CR, 1'b1);
    send_byte("z", 1'b1);
  endtask

  task automatic test_random_records(input logic [7:0] sep, input int count);
    int target;
    int nf;
    int len;
    write_delimiter(sep);
    target = random_sent + count;
    while (random_sent < target) begin
      if ($urandom_range(9) < 7) begin
        nf = $urandom_range(4, 1);
        for (int f = 0; f < nf; f++) begin
          if (f > 0) put_random(field_sep);
          len = $urandom_range(5);
          if ($urandom_range(1) == 0) begin
            put_random(CH_QUOTE);
            for (int k = 0; k < len; k++) begin
              case ($urandom_range(19))
                0, 1: begin
                  put_random(CH_QUOTE);
                  put_random(CH_QUOTE);
                end
                2, 3: put_random(field_sep);
                4: put_random(CH_LF);
                5: put_random(CH_CR);
                6: put_random(CH_BACKSLASH);
                default: put_random(plain_char());
              endcase
            end
            put_random(CH_QUOTE);
          end else begin
            for (int k = 0; k < len; k++) put_random(plain_char());
          end
        end
        case ($urandom_range(9))
          0, 1, 2, 3, 4: put_random(CH_LF);
          5, 6, 7: begin
            put_random(CH_CR);
            put_random(CH_LF);
          end
          8: begin
            put_random(CH_LF);
            put_random(CH_LF);
          end
          default: ;
        endcase
      end else begin
        len = $urandom_range(6, 1);
        for (int k = 0; k < len; k++) put_random(any_char());
      end
    end
  endtask

  // result checker and receiver stalls
  initial begin
    split_result_t want;
    split_result_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got = '{out_ch.out_byte, out_ch.byte_valid, out_ch.field_end,
                out_ch.record_end, out_ch.last};
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result byte=%h bv=%b fe=%b re=%b last=%b", $time,
                   got.ob, got.bv, got.fe, got.re, got.is_last);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.ob !== want.ob || got.bv !== want.bv || got.fe !== want.fe ||
              got.re !== want.re || got.is_last !== want.is_last) begin
            $display("%0t: expected byte=%h bv=%b fe=%b re=%b last=%b", $time,
                     want.ob, want.bv, want.fe, want.re, want.is_last);
            $display("%0t: actual   byte=%h bv=%b fe=%b re=%b last=%b", $time,
                     got.ob, got.bv, got.fe, got.re, got.is_last);
            mismatch_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= 8'h00;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= 8'h00;
    in_ch.last_byte <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 11;
    recv_idle_pct = 45;
    test_plain_fields();
    test_quoted_fields();
    test_escape_and_stream_end();
    test_random_records(DELIM_RESET, 120);
    test_random_records(8'h00, 60);

    send_idle_pct = 45;
    recv_idle_pct = 11;
    test_random_records(8'hFF, 60);
    test_random_records(8'h09, 120);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_records(CH_QUOTE, 40);
    test_random_records(CH_LF, 40);
    test_random_records(CH_CR, 30);
    test_random_records(8'h3B, 120);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  final begin
  end
endmodule

### sim.f
design/csvfs_pkg.sv
design/csvfs_ifs.sv
design/csvfs_front.sv
design/csvfs_queue.sv
design/csvfs_back.sv
design/csv_record_field_splitter.sv
test/testbench.sv
